// File: design/hasm_pkg.sv
// Package for the hysteresis alarm monitor with windowed statistics.
// Holds the shared widths, register indexes, reset values and the
// command and status structures between controller and datapath.
package hasm_pkg;

    // Fixed widths of the register file and the window accumulators.
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int LEVEL_W   = 16;
    localparam int LIMIT_W   = 8;
    localparam int TICK_W    = 32;
    localparam int SUM_W     = 48;
    localparam int PROD_W    = 64;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALARM_LEVEL    = 3'd0,
        REG_RESUME_LEVEL   = 3'd1,
        REG_SAMPLE_PERIOD  = 3'd2,
        REG_STAT_PERIOD    = 3'd3,
        REG_SILENCE_PERIOD = 3'd4,
        REG_REPORT_LIMIT   = 3'd5,
        REG_MIN_START      = 3'd6
    } cfg_reg_t;

    // Register values after reset.
    localparam logic [LEVEL_W-1:0] ALARM_LEVEL_RST    = 16'd5;
    localparam logic [LEVEL_W-1:0] RESUME_LEVEL_RST   = 16'd3;
    localparam logic [TICK_W-1:0]  SAMPLE_PERIOD_RST  = 32'd10000;
    localparam logic [TICK_W-1:0]  STAT_PERIOD_RST    = 32'd3600000;
    localparam logic [TICK_W-1:0]  SILENCE_PERIOD_RST = 32'd60000;
    localparam logic [LIMIT_W-1:0] REPORT_LIMIT_RST   = 8'd9;
    localparam logic [LEVEL_W-1:0] MIN_START_RST      = 16'd100;

    // Operand choice for the shared period multiplier.
    typedef enum logic [1:0] {
        MUL_SILENCE  = 2'd0,
        MUL_WINDOW   = 2'd1,
        MUL_DURATION = 2'd2
    } mul_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load_sample;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     sil_check;
        logic     win_check;
        logic     dur_capture;
        logic     div_start;
        logic     out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic win_hit;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

// File: design/hasm_stream_if.sv
// Valid/ready channel interfaces for the alarm monitor: the sample word in
// and the result word out. Counts are COUNT_WIDTH wide, totals and duration TICK_W from hasm_pkg.
interface hasm_sample_if #(parameter int COUNT_WIDTH = 16);
    logic                   valid;
    logic                   ready;
    logic [COUNT_WIDTH-1:0] count;

    modport source (output valid, output count, input ready);
    modport sink   (input valid, input count, output ready);
endinterface

interface hasm_result_if #(parameter int COUNT_WIDTH = 16);
    logic                          valid;
    logic                          ready;
    logic                          alarm_raised;
    logic                          alarm_reported;
    logic                          resumed;
    logic                          in_alarm;
    logic                          stat_ready;
    logic [COUNT_WIDTH-1:0]        min_count;
    logic [COUNT_WIDTH-1:0]        max_count;
    logic [COUNT_WIDTH-1:0]        avg_count;
    logic [hasm_pkg::TICK_W-1:0]   alarm_total;
    logic [hasm_pkg::TICK_W-1:0]   resume_total;
    logic [hasm_pkg::TICK_W-1:0]   alarm_duration_ms;

    modport source (
        output valid, output alarm_raised, output alarm_reported, output resumed,
        output in_alarm, output stat_ready, output min_count, output max_count,
        output avg_count, output alarm_total, output resume_total,
        output alarm_duration_ms, input ready
    );
    modport sink (
        input valid, input alarm_raised, input alarm_reported, input resumed,
        input in_alarm, input stat_ready, input min_count, input max_count,
        input avg_count, input alarm_total, input resume_total,
        input alarm_duration_ms, output ready
    );
endinterface

// File: design/hasm_div.sv
// Restoring divider, one quotient bit per cycle, for the window average.
// Quotient is saturated to the count range; a zero divisor gives zero.
// Depends on hasm_pkg.
module hasm_div #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [hasm_pkg::SUM_W-1:0]   dividend,
    input  logic [hasm_pkg::TICK_W-1:0]  divisor,
    output logic                         done,
    output logic [COUNT_WIDTH-1:0]       quotient
);
    localparam int SUM_W  = hasm_pkg::SUM_W;
    localparam int DIV_W  = hasm_pkg::TICK_W;
    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic              zero_reg;
    logic [STEP_W-1:0] step_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  div_reg;
    logic [DIV_W:0]    rem_shift;
    logic              fits;

    // Trial subtraction of one step.
    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign fits      = rem_shift >= {1'b0, div_reg};

    // Iteration control and the remainder/quotient shift.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg  <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
            zero_reg <= (divisor == '0);
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= DIV_W'(rem_shift - {1'b0, div_reg});
            end
            else
            begin
                rem_reg <= rem_shift[DIV_W-1:0];
            end
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
        end
    end

    // Saturate to the count range.
    always_comb
    begin
        if (zero_reg)
        begin
            quotient = '0;
        end
        else if ((quo_reg >> COUNT_WIDTH) != '0)
        begin
            quotient = '1;
        end
        else
        begin
            quotient = quo_reg[COUNT_WIDTH-1:0];
        end
    end

    assign done = done_reg && !busy_reg;

endmodule

// File: design/hasm_dp.sv
// Datapath of the alarm monitor: configuration registers, alarm and window
// state, the shared period multiplier, the divider and the result register.
// Depends on hasm_pkg, hasm_result_if and hasm_div.
module hasm_dp #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [hasm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hasm_pkg::CFG_W-1:0]      cfg_data,
    input  logic [COUNT_WIDTH-1:0]          count,
    input  hasm_pkg::dp_cmd_t               cmd,
    output hasm_pkg::dp_status_t            status,
    hasm_result_if.source                   results
);
    localparam int LEVEL_W = hasm_pkg::LEVEL_W;
    localparam int LIMIT_W = hasm_pkg::LIMIT_W;
    localparam int TICK_W  = hasm_pkg::TICK_W;
    localparam int SUM_W   = hasm_pkg::SUM_W;
    localparam int PROD_W  = hasm_pkg::PROD_W;
    localparam int CMP_W   = (COUNT_WIDTH > LEVEL_W) ? COUNT_WIDTH : LEVEL_W;

    // Configuration registers.
    logic [LEVEL_W-1:0] alarm_level_reg;
    logic [LEVEL_W-1:0] resume_level_reg;
    logic [TICK_W-1:0]  sample_period_reg;
    logic [TICK_W-1:0]  stat_period_reg;
    logic [TICK_W-1:0]  silence_period_reg;
    logic [LIMIT_W-1:0] report_limit_reg;
    logic [LEVEL_W-1:0] min_start_reg;

    // Alarm and window state.
    logic                   flag_reg;
    logic                   silence_on_reg;
    logic [TICK_W-1:0]      silence_ticks_reg;
    logic [LIMIT_W-1:0]     reports_reg;
    logic [TICK_W-1:0]      window_samples_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [CMP_W-1:0]       min_seen_reg;
    logic [COUNT_WIDTH-1:0] max_seen_reg;
    logic [TICK_W-1:0]      alarm_events_reg;
    logic [TICK_W-1:0]      resume_events_reg;
    logic [TICK_W-1:0]      alarm_ticks_reg;

    // Per-word flags and working registers.
    logic               raised_reg;
    logic               reported_reg;
    logic               resumed_reg;
    logic               stat_ready_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [TICK_W-1:0]  dur_reg;
    logic               out_valid_reg;

    // Sample decode.
    logic [CMP_W-1:0]       cnt_ext;
    logic                   raise;
    logic                   fall;
    logic                   start_timer;
    logic                   report;
    logic                   flag_next;
    logic                   silence_run;
    logic [TICK_W-1:0]      silence_ticks_next;
    logic [TICK_W-1:0]      mul_a;
    logic [COUNT_WIDTH-1:0] avg_q;
    logic                   div_done;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_level_reg    <= hasm_pkg::ALARM_LEVEL_RST;
            resume_level_reg   <= hasm_pkg::RESUME_LEVEL_RST;
            sample_period_reg  <= hasm_pkg::SAMPLE_PERIOD_RST;
            stat_period_reg    <= hasm_pkg::STAT_PERIOD_RST;
            silence_period_reg <= hasm_pkg::SILENCE_PERIOD_RST;
            report_limit_reg   <= hasm_pkg::REPORT_LIMIT_RST;
            min_start_reg      <= hasm_pkg::MIN_START_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (hasm_pkg::cfg_reg_t'(cfg_index))
                hasm_pkg::REG_ALARM_LEVEL:    alarm_level_reg    <= cfg_data[LEVEL_W-1:0];
                hasm_pkg::REG_RESUME_LEVEL:   resume_level_reg   <= cfg_data[LEVEL_W-1:0];
                hasm_pkg::REG_SAMPLE_PERIOD:  sample_period_reg  <= cfg_data[TICK_W-1:0];
                hasm_pkg::REG_STAT_PERIOD:    stat_period_reg    <= cfg_data[TICK_W-1:0];
                hasm_pkg::REG_SILENCE_PERIOD: silence_period_reg <= cfg_data[TICK_W-1:0];
                hasm_pkg::REG_REPORT_LIMIT:   report_limit_reg   <= cfg_data[LIMIT_W-1:0];
                hasm_pkg::REG_MIN_START:      min_start_reg      <= cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Hysteresis decision for the incoming sample; a rise wins over a fall.
    always_comb
    begin
        cnt_ext     = CMP_W'(count);
        raise       = (cnt_ext >= CMP_W'(alarm_level_reg)) && !flag_reg;
        fall        = !raise && (cnt_ext < CMP_W'(resume_level_reg)) && flag_reg;
        start_timer = raise && !silence_on_reg;
        report      = start_timer && (reports_reg < report_limit_reg);
        flag_next   = raise ? 1'b1 : (fall ? 1'b0 : flag_reg);
        silence_run = silence_on_reg || start_timer;
        silence_ticks_next = (start_timer ? '0 : silence_ticks_reg) + 1'b1;
    end

    // Operand select for the period multiplier.
    always_comb
    begin
        case (cmd.mul_sel)
            hasm_pkg::MUL_SILENCE:  mul_a = silence_ticks_reg;
            hasm_pkg::MUL_WINDOW:   mul_a = window_samples_reg;
            hasm_pkg::MUL_DURATION: mul_a = alarm_ticks_reg;
            default:                mul_a = '0;
        endcase
    end

    // Alarm state, window accumulators and the window clear.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg           <= 1'b0;
            silence_on_reg     <= 1'b0;
            silence_ticks_reg  <= '0;
            reports_reg        <= '0;
            window_samples_reg <= '0;
            sum_reg            <= '0;
            min_seen_reg       <= CMP_W'(hasm_pkg::MIN_START_RST);
            max_seen_reg       <= '0;
            alarm_events_reg   <= '0;
            resume_events_reg  <= '0;
            alarm_ticks_reg    <= '0;
            stat_ready_reg     <= 1'b0;
        end
        else if (cmd.load_sample)
        begin
            if (cnt_ext < min_seen_reg)
            begin
                min_seen_reg <= cnt_ext;
            end
            if (count > max_seen_reg)
            begin
                max_seen_reg <= count;
            end
            sum_reg            <= sum_reg + SUM_W'(count);
            flag_reg           <= flag_next;
            silence_on_reg     <= silence_run;
            if (silence_run)
            begin
                silence_ticks_reg <= silence_ticks_next;
            end
            reports_reg        <= reports_reg + LIMIT_W'(report);
            alarm_events_reg   <= alarm_events_reg + TICK_W'(raise);
            resume_events_reg  <= resume_events_reg + TICK_W'(fall);
            window_samples_reg <= window_samples_reg + 1'b1;
            alarm_ticks_reg    <= alarm_ticks_reg + TICK_W'(flag_next);
        end
        else if (cmd.sil_check)
        begin
            if (silence_on_reg && (prod_reg >= PROD_W'(silence_period_reg)))
            begin
                silence_on_reg <= 1'b0;
            end
        end
        else if (cmd.win_check)
        begin
            stat_ready_reg <= status.win_hit;
        end
        else if (cmd.out_load && stat_ready_reg)
        begin
            stat_ready_reg     <= 1'b0;
            reports_reg        <= '0;
            window_samples_reg <= '0;
            sum_reg            <= '0;
            min_seen_reg       <= CMP_W'(min_start_reg);
            max_seen_reg       <= '0;
            alarm_events_reg   <= '0;
            resume_events_reg  <= '0;
            alarm_ticks_reg    <= '0;
        end
    end

    // Per-word event flags, the product register and the duration.
    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            raised_reg   <= raise;
            reported_reg <= report;
            resumed_reg  <= fall;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(sample_period_reg);
        end
        if (cmd.dur_capture)
        begin
            dur_reg <= prod_reg[TICK_W-1:0];
        end
    end

    // Window average.
    hasm_div #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (window_samples_reg),
        .done     (div_done),
        .quotient (avg_q)
    );

    // Result register; the stat fields read zero unless the window closed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            results.alarm_raised   <= raised_reg;
            results.alarm_reported <= reported_reg;
            results.resumed        <= resumed_reg;
            results.in_alarm       <= flag_reg;
            results.stat_ready     <= stat_ready_reg;
            if (stat_ready_reg)
            begin
                results.min_count         <= min_seen_reg[COUNT_WIDTH-1:0];
                results.max_count         <= max_seen_reg;
                results.avg_count         <= avg_q;
                results.alarm_total       <= alarm_events_reg;
                results.resume_total      <= resume_events_reg;
                results.alarm_duration_ms <= dur_reg;
            end
            else
            begin
                results.min_count         <= '0;
                results.max_count         <= '0;
                results.avg_count         <= '0;
                results.alarm_total       <= '0;
                results.resume_total      <= '0;
                results.alarm_duration_ms <= '0;
            end
        end
    end

    assign results.valid   = out_valid_reg;

    // Status back to the controller.
    assign status.win_hit  = prod_reg >= PROD_W'(stat_period_reg);
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || results.ready;

endmodule

// File: design/hasm_ctrl.sv
// Controller of the alarm monitor: sequences sample update, the period
// products, the optional average division and the result load.
// Depends on hasm_pkg.
module hasm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  hasm_pkg::dp_status_t  status,
    output hasm_pkg::dp_cmd_t     cmd
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_SIL,
        S_MUL_WIN,
        S_CHK_WIN,
        S_DUR,
        S_DIV,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (in_valid) state_next = S_MUL_SIL;
            S_MUL_SIL: state_next = S_MUL_WIN;
            S_MUL_WIN: state_next = S_CHK_WIN;
            S_CHK_WIN: state_next = status.win_hit ? S_DUR : S_DONE;
            S_DUR:     state_next = S_DIV;
            S_DIV:     if (status.div_done) state_next = S_DONE;
            S_DONE:    if (status.out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Commands decoded from the state.
    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = hasm_pkg::MUL_SILENCE;
        unique case (state_reg)
            S_IDLE:    cmd.load_sample = in_valid;
            S_MUL_SIL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = hasm_pkg::MUL_SILENCE;
            end
            S_MUL_WIN:
            begin
                cmd.sil_check = 1'b1;
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = hasm_pkg::MUL_WINDOW;
            end
            S_CHK_WIN:
            begin
                cmd.win_check = 1'b1;
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = hasm_pkg::MUL_DURATION;
            end
            S_DUR:
            begin
                cmd.dur_capture = 1'b1;
                cmd.div_start   = 1'b1;
            end
            S_DIV:     cmd.out_load = 1'b0;
            S_DONE:    cmd.out_load = status.out_free;
            default:   cmd = '0;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

// File: design/hysteresis_alarm_stat_monitor_top.sv
// Hysteresis alarm monitor with windowed statistics. Each sample word gives
// one result word. A sample that does not close the statistics window goes
// from acceptance to the result register through update, silence product,
// window product, window check and load; one that closes the window also
// waits for the 48-step bit-serial divider that forms the average. One 32x32
// multiplier is shared by the silence, window and duration products. Results
// wait in an output register, so the next sample is taken while a result is
// still pending. Configuration is written through cfg_wr_en/cfg_index/cfg_data
// while the block is idle; the user must ensure it, as the block does not check.
module hysteresis_alarm_stat_monitor_top #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [hasm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hasm_pkg::CFG_W-1:0]      cfg_data,
    hasm_sample_if.sink                     samples,
    hasm_result_if.source                   results
);
    hasm_pkg::dp_cmd_t    cmd;
    hasm_pkg::dp_status_t status;
    logic                 in_ready;
    logic [COUNT_WIDTH-1:0] sample_count;

    assign samples.ready = in_ready;
    assign sample_count  = samples.count;

    // Sequencer.
    hasm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // State, arithmetic and result register.
    hasm_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .count     (sample_count),
        .cmd       (cmd),
        .status    (status),
        .results   (results)
    );

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// Testbench for hysteresis_alarm_stat_monitor_top: a directed list of sample words and
// register writes, then randomized phases. A built-in predictor checks every result word.
// Depends on hasm_pkg and the stream interfaces.
module tb;

    localparam int CW           = 16;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 55;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 60;

    // Flag patterns of a result word: raised, reported, resumed, in_alarm, stat_ready.
    localparam logic [4:0] F_NONE     = 5'b00000;
    localparam logic [4:0] F_RAISED   = 5'b10000;
    localparam logic [4:0] F_REPORTED = 5'b01000;
    localparam logic [4:0] F_RESUMED  = 5'b00100;
    localparam logic [4:0] F_IN_ALARM = 5'b00010;

    typedef struct packed {
        logic          alarm_raised;
        logic          alarm_reported;
        logic          resumed;
        logic          in_alarm;
        logic          stat_ready;
        logic [CW-1:0] min_count;
        logic [CW-1:0] max_count;
        logic [CW-1:0] avg_count;
        logic [31:0]   alarm_total;
        logic [31:0]   resume_total;
        logic [31:0]   alarm_duration_ms;
    } alarm_word_t;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t           kind;
        hasm_pkg::cfg_reg_t  reg_idx;
        logic [31:0]         data;
        logic [CW-1:0]       count;
        logic                typed;
        logic [4:0]          flags;
    } step_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_wr_en;
    logic [hasm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [hasm_pkg::CFG_W-1:0]     cfg_data;

    hasm_sample_if #(.COUNT_WIDTH(CW)) sample_ch ();
    hasm_result_if #(.COUNT_WIDTH(CW)) result_ch ();

    hysteresis_alarm_stat_monitor_top #(.COUNT_WIDTH(CW)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (sample_ch),
        .results   (result_ch)
    );

    // Register copies kept by the predictor.
    logic [15:0] alarm_lvl, resume_lvl, first_min;
    logic [31:0] sample_ms, stat_ms, silence_ms;
    logic [7:0]  report_cap;

    // Monitor state kept by the predictor.
    logic        flag_q, silence_q;
    logic [31:0] silence_ticks, win_samples, raise_events, clear_events, alarmed_ticks;
    logic [7:0]  win_reports;
    logic [47:0] win_sum;
    logic [15:0] win_min, win_max;

    alarm_word_t alarm_words_due[$];
    step_t       plan[$];
    int          mismatches = 0;
    int          cycle_count = 0;
    int          send_calm = 0;
    int          take_calm = 0;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Start of a statistics window; the flag and the silence timer are kept.
    function automatic void open_window();
        win_reports   = '0;
        win_samples   = '0;
        win_sum       = '0;
        win_min       = first_min;
        win_max       = '0;
        raise_events  = '0;
        clear_events  = '0;
        alarmed_ticks = '0;
    endfunction

    function automatic void reset_monitor();
        alarm_lvl     = hasm_pkg::ALARM_LEVEL_RST;
        resume_lvl    = hasm_pkg::RESUME_LEVEL_RST;
        sample_ms     = hasm_pkg::SAMPLE_PERIOD_RST;
        stat_ms       = hasm_pkg::STAT_PERIOD_RST;
        silence_ms    = hasm_pkg::SILENCE_PERIOD_RST;
        report_cap    = hasm_pkg::REPORT_LIMIT_RST;
        first_min     = hasm_pkg::MIN_START_RST;
        flag_q        = 1'b0;
        silence_q     = 1'b0;
        silence_ticks = '0;
        open_window();
    endfunction

    function automatic void set_monitor_reg(hasm_pkg::cfg_reg_t idx, logic [31:0] d);
        case (idx)
            hasm_pkg::REG_ALARM_LEVEL:    alarm_lvl  = d[15:0];
            hasm_pkg::REG_RESUME_LEVEL:   resume_lvl = d[15:0];
            hasm_pkg::REG_SAMPLE_PERIOD:  sample_ms  = d;
            hasm_pkg::REG_STAT_PERIOD:    stat_ms    = d;
            hasm_pkg::REG_SILENCE_PERIOD: silence_ms = d;
            hasm_pkg::REG_REPORT_LIMIT:   report_cap = d[7:0];
            hasm_pkg::REG_MIN_START:      first_min  = d[15:0];
            default: ;
        endcase
    endfunction

    // One sample through the monitor: hysteresis, silence timer and window close.
    function automatic alarm_word_t monitor_step(logic [CW-1:0] c);
        alarm_word_t w;
        logic [63:0] prod;
        logic [47:0] quot;
        w = '0;
        if (c < win_min) win_min = c;
        if (c > win_max) win_max = c;
        win_sum = win_sum + {32'd0, c};

        // A rise is checked first; a fall only when there was no rise.
        if (c >= alarm_lvl && !flag_q) begin
            flag_q         = 1'b1;
            w.alarm_raised = 1'b1;
            if (!silence_q) begin
                silence_q     = 1'b1;
                silence_ticks = '0;
                if (win_reports < report_cap) begin
                    w.alarm_reported = 1'b1;
                    win_reports      = win_reports + 8'd1;
                end
            end
            raise_events = raise_events + 32'd1;
        end else if (c < resume_lvl && flag_q) begin
            flag_q       = 1'b0;
            w.resumed    = 1'b1;
            clear_events = clear_events + 32'd1;
        end

        win_samples = win_samples + 32'd1;
        if (flag_q) alarmed_ticks = alarmed_ticks + 32'd1;
        if (silence_q) silence_ticks = silence_ticks + 32'd1;
        prod = {32'd0, silence_ticks} * {32'd0, sample_ms};
        if (silence_q && prod >= {32'd0, silence_ms}) silence_q = 1'b0;

        // Window close compares the exact 64-bit product.
        prod = {32'd0, win_samples} * {32'd0, sample_ms};
        if (prod >= {32'd0, stat_ms}) begin
            w.stat_ready   = 1'b1;
            w.min_count    = win_min;
            w.max_count    = win_max;
            quot           = (win_samples == 0) ? 48'd0 : win_sum / {16'd0, win_samples};
            w.avg_count    = (quot > 48'hFFFF) ? 16'hFFFF : quot[15:0];
            w.alarm_total  = raise_events;
            w.resume_total = clear_events;
            prod           = {32'd0, alarmed_ticks} * {32'd0, sample_ms};
            w.alarm_duration_ms = prod[31:0];
            open_window();
        end
        w.in_alarm = flag_q;
        return w;
    endfunction

    // Wait cycles before the next word; now and then a run of back-to-back words.
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(8, 30);
        return $urandom_range(0, 17);
    endfunction

    // Counts cluster around the two levels, with some full-range noise.
    function automatic logic [CW-1:0] draw_count();
        int sel, v, lo, hi;
        sel = $urandom_range(0, 9);
        if (sel < 2) return CW'($urandom);
        lo = (alarm_lvl < resume_lvl) ? int'(alarm_lvl) : int'(resume_lvl);
        hi = (alarm_lvl < resume_lvl) ? int'(resume_lvl) : int'(alarm_lvl);
        if (sel >= 8) return CW'($urandom_range(hi, lo));
        v = (sel < 5) ? int'(alarm_lvl) : int'(resume_lvl);
        v = v + int'($urandom_range(0, 8)) - 4;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return CW'(v);
    endfunction

    function automatic logic [31:0] span_ms(logic [31:0] per, int unsigned k);
        logic [63:0] p;
        p = {32'd0, per} * 64'(k);
        return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
    endfunction

    function automatic step_t sample_row(logic [CW-1:0] c, logic typed, logic [4:0] flags);
        step_t s;
        s = '{ROW_SAMPLE, hasm_pkg::REG_ALARM_LEVEL, 32'd0, c, typed, flags};
        return s;
    endfunction

    function automatic step_t write_row(hasm_pkg::cfg_reg_t idx, logic [31:0] d);
        step_t s;
        s = '{ROW_WRITE, idx, d, '0, 1'b0, F_NONE};
        return s;
    endfunction

    // The caller lowers cfg_wr_en after the last write of a group.
    task automatic write_reg(hasm_pkg::cfg_reg_t idx, logic [31:0] d);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        set_monitor_reg(idx, d);
        @(posedge clk);
    endtask

    // Returns at the edge that accepts the sample word.
    task automatic send_sample(logic [CW-1:0] c);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.count <= c;
        do @(posedge clk); while (!sample_ch.ready);
    endtask

    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        while (alarm_words_due.size() != 0) @(posedge clk);
    endtask

    task automatic note_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%s mismatch: expected %0d (0x%0h), actual %0d (0x%0h)",
                         name, want, want, got, got);
        end
    endtask

    task automatic match_word(alarm_word_t got);
        alarm_word_t want;
        if (alarm_words_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("result word with no sample pending");
            return;
        end
        want = alarm_words_due.pop_front();
        note_field("alarm_raised", want.alarm_raised, got.alarm_raised);
        note_field("alarm_reported", want.alarm_reported, got.alarm_reported);
        note_field("resumed", want.resumed, got.resumed);
        note_field("in_alarm", want.in_alarm, got.in_alarm);
        note_field("stat_ready", want.stat_ready, got.stat_ready);
        note_field("min_count", want.min_count, got.min_count);
        note_field("max_count", want.max_count, got.max_count);
        note_field("avg_count", want.avg_count, got.avg_count);
        note_field("alarm_total", want.alarm_total, got.alarm_total);
        note_field("resume_total", want.resume_total, got.resume_total);
        note_field("alarm_duration_ms", want.alarm_duration_ms, got.alarm_duration_ms);
    endtask

    // Register settings of one random phase; the first three are fixed corners.
    task automatic pick_setting(int ph);
        logic [15:0] a, r, m;
        logic [31:0] sp, st, si;
        logic [7:0]  cap;
        int          t;
        if (ph == 0) begin
            // Top of every range but the resume level and min start: each sample closes the window.
            a = 16'hFFFF; r = 16'h0000; m = 16'h0000;
            sp = 32'hFFFF_FFFF; st = 32'hFFFF_FFFF; si = 32'hFFFF_FFFF; cap = 8'hFF;
        end else if (ph == 1) begin
            // Bottom of most ranges, min start at the top: no alarm may be reported.
            a = 16'h0000; r = 16'h0000; m = 16'hFFFF;
            sp = 32'd1; st = $urandom_range(1, 30); si = $urandom_range(1, 8); cap = 8'h00;
        end else if (ph == 2) begin
            // Zero sample period: the window and the silence timer never end.
            a = 16'($urandom); r = a - 16'($urandom_range(0, 20)); m = 16'($urandom);
            sp = 32'd0; st = $urandom | 32'd1; si = $urandom | 32'd1; cap = 8'd3;
        end else begin
            a = 16'($urandom);
            if ($urandom_range(0, 3) == 0) t = int'(a) + int'($urandom_range(1, 40));
            else t = int'(a) - int'($urandom_range(0, 40));
            if (t < 0) t = 0;
            if (t > 65535) t = 65535;
            r   = 16'(t);
            m   = 16'($urandom);
            sp  = ph[0] ? 32'($urandom_range(1, 5000)) : ($urandom | 32'd1);
            st  = span_ms(sp, $urandom_range(1, 40));
            si  = span_ms(sp, $urandom_range(1, 12));
            cap = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
        end
        write_reg(hasm_pkg::REG_ALARM_LEVEL, {16'd0, a});
        write_reg(hasm_pkg::REG_RESUME_LEVEL, {16'd0, r});
        write_reg(hasm_pkg::REG_SAMPLE_PERIOD, sp);
        write_reg(hasm_pkg::REG_STAT_PERIOD, st);
        write_reg(hasm_pkg::REG_SILENCE_PERIOD, si);
        write_reg(hasm_pkg::REG_REPORT_LIMIT, {24'd0, cap});
        write_reg(hasm_pkg::REG_MIN_START, {16'd0, m});
        cfg_wr_en <= 1'b0;
    endtask

    // Result side: random stalls, one check per accepted result word.
    initial begin : result_side
        alarm_word_t got;
        int          gap;
        result_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            gap = draw_wait(take_calm);
            if (gap > 0) begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
            got.alarm_raised      = result_ch.alarm_raised;
            got.alarm_reported    = result_ch.alarm_reported;
            got.resumed           = result_ch.resumed;
            got.in_alarm          = result_ch.in_alarm;
            got.stat_ready        = result_ch.stat_ready;
            got.min_count         = result_ch.min_count;
            got.max_count         = result_ch.max_count;
            got.avg_count         = result_ch.avg_count;
            got.alarm_total       = result_ch.alarm_total;
            got.resume_total      = result_ch.resume_total;
            got.alarm_duration_ms = result_ch.alarm_duration_ms;
            match_word(got);
        end
    end

    // Sample side: reset, directed list, then random phases.
    initial begin : sample_side
        step_t         row;
        alarm_word_t   due;
        logic [CW-1:0] c;
        int            i, ph, n;
        rst_n           <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_index       <= hasm_pkg::REG_ALARM_LEVEL;
        cfg_data        <= '0;
        sample_ch.valid <= 1'b0;
        sample_ch.count <= '0;
        reset_monitor();

        // Reset values: a rise at the alarm level, hold through the resume level,
        // then a second rise while the silence timer still runs goes unreported.
        plan.push_back(sample_row(16'd0, 1'b1, F_NONE));
        plan.push_back(sample_row(16'd4, 1'b1, F_NONE));
        plan.push_back(sample_row(16'd5, 1'b1, F_RAISED | F_REPORTED | F_IN_ALARM));
        plan.push_back(sample_row(16'hFFFF, 1'b1, F_IN_ALARM));
        plan.push_back(sample_row(16'd3, 1'b1, F_IN_ALARM));
        plan.push_back(sample_row(16'd2, 1'b1, F_RESUMED));
        plan.push_back(sample_row(16'd5, 1'b1, F_RAISED | F_IN_ALARM));
        // Short windows and timer, one report per window; the new min_start only
        // shows from the next window on.
        plan.push_back(write_row(hasm_pkg::REG_SAMPLE_PERIOD, 32'd1));
        plan.push_back(write_row(hasm_pkg::REG_STAT_PERIOD, 32'd3));
        plan.push_back(write_row(hasm_pkg::REG_SILENCE_PERIOD, 32'd2));
        plan.push_back(write_row(hasm_pkg::REG_REPORT_LIMIT, 32'd1));
        plan.push_back(write_row(hasm_pkg::REG_MIN_START, 32'hFFFF));
        plan.push_back(sample_row(16'hFFFF, 1'b0, F_NONE));
        plan.push_back(sample_row(16'd0, 1'b0, F_NONE));
        plan.push_back(sample_row(16'hFFFF, 1'b0, F_NONE));
        plan.push_back(sample_row(16'd0, 1'b0, F_NONE));
        plan.push_back(sample_row(16'hFFFF, 1'b0, F_NONE));
        plan.push_back(sample_row(16'd0, 1'b0, F_NONE));
        plan.push_back(sample_row(16'd9, 1'b0, F_NONE));
        // Alarm level at zero and resume level at the top: rise and fall alternate, but a top sample holds the alarm.
        plan.push_back(write_row(hasm_pkg::REG_ALARM_LEVEL, 32'd0));
        plan.push_back(write_row(hasm_pkg::REG_RESUME_LEVEL, 32'hFFFF));
        plan.push_back(sample_row(16'd100, 1'b0, F_NONE));
        plan.push_back(sample_row(16'd100, 1'b0, F_NONE));
        plan.push_back(sample_row(16'hFFFF, 1'b0, F_NONE));
        plan.push_back(sample_row(16'd0, 1'b0, F_NONE));
        // Zero sample period with a zero stat period closes every window.
        plan.push_back(write_row(hasm_pkg::REG_SAMPLE_PERIOD, 32'd0));
        plan.push_back(write_row(hasm_pkg::REG_STAT_PERIOD, 32'd0));
        plan.push_back(write_row(hasm_pkg::REG_SILENCE_PERIOD, 32'hFFFF_FFFF));
        plan.push_back(sample_row(16'd7, 1'b0, F_NONE));
        plan.push_back(sample_row(16'hFFFF, 1'b0, F_NONE));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < plan.size(); i++) begin
            row = plan[i];
            if (row.kind == ROW_WRITE) begin
                if (i == 0 || plan[i-1].kind != ROW_WRITE) drain_results();
                write_reg(row.reg_idx, row.data);
                if (i + 1 == plan.size() || plan[i+1].kind != ROW_WRITE)
                    cfg_wr_en <= 1'b0;
            end else begin
                send_sample(row.count);
                due = monitor_step(row.count);
                if (row.typed) begin
                    due = '0;
                    {due.alarm_raised, due.alarm_reported, due.resumed,
                     due.in_alarm, due.stat_ready} = row.flags;
                end
                alarm_words_due.push_back(due);
            end
        end

        for (ph = 0; ph < PHASES; ph++) begin
            drain_results();
            pick_setting(ph);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                c = draw_count();
                send_sample(c);
                alarm_words_due.push_back(monitor_step(c));
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
